// ===== src/wfc_pkg.sv =====
// wfc_pkg: shared constants, types and character helpers for the word counter.
// Depends on nothing; used by every file under src.
package wfc_pkg;

    localparam int DEF_MAX_WORDS   = 256;
    localparam int DEF_MAX_LETTERS = 32;
    localparam int COUNT_W         = 24;
    localparam int INDEX_W         = 8;
    localparam int OUT_LEN_W       = 6;
    localparam int LETTER_W        = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UZ    = 8'd90;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LZ    = 8'd122;

    typedef struct packed {
        logic is_new;
        logic table_full_drop;
        logic word_truncated;
    } res_flags_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    // letter code 0..25, case folded
    function automatic logic [LETTER_W-1:0] letter_code(input logic [7:0] c);
        logic [7:0] d;
        d = (c >= CH_LA) ? (c - CH_LA) : (c - CH_UA);
        letter_code = d[LETTER_W-1:0];
    endfunction

endpackage

// ===== src/wfc_front.sv =====
// wfc_front: takes text bytes, assembles the current token, emits finished tokens.
// Depends on wfc_pkg.
module wfc_front import wfc_pkg::*; #(
    parameter int MAX_LETTERS = DEF_MAX_LETTERS,
    parameter int LEN_W       = $clog2(MAX_LETTERS + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_text_byte,
    input  logic                            s_end_of_text,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [MAX_LETTERS*LETTER_W-1:0] q_letters,
    output logic [LEN_W-1:0]                q_len,
    output logic                            q_ovf
);
    localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;

    logic [MAX_LETTERS*LETTER_W-1:0] letters_reg, letters_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic                            ovf_reg, ovf_next;
    logic                            in_tok_reg, in_tok_next;
    logic                            accept;
    logic [IDX_W-1:0]                wr_idx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign wr_idx  = len_reg[IDX_W-1:0];

    always_comb begin
        letters_next = letters_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        in_tok_next  = in_tok_reg;
        q_push       = 1'b0;
        q_letters    = letters_reg;
        q_len        = len_reg;
        q_ovf        = ovf_reg;
        if (accept) begin
            if (is_blank(s_text_byte)) begin
                if (in_tok_reg) begin
                    q_push      = 1'b1;
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    in_tok_next = 1'b0;
                end
            end else begin
                if (is_letter(s_text_byte)) begin
                    if (len_reg < LEN_W'(MAX_LETTERS)) begin
                        letters_next[wr_idx*LETTER_W +: LETTER_W] = letter_code(s_text_byte);
                        len_next = len_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                q_letters = letters_next;
                q_len     = len_next;
                q_ovf     = ovf_next;
                if (s_end_of_text) begin
                    q_push      = 1'b1;
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    in_tok_next = 1'b0;
                end else begin
                    in_tok_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        letters_reg <= letters_next;
        if (!aresetn) begin
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            in_tok_reg <= 1'b0;
        end else begin
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            in_tok_reg <= in_tok_next;
        end
    end

endmodule

// ===== src/wfc_fifo.sv =====
// wfc_fifo: two-entry queue of finished tokens between front and back.
// Depends on wfc_pkg for its default width; no shared types needed.
module wfc_fifo import wfc_pkg::*; #(
    parameter int W = DEF_MAX_LETTERS * LETTER_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= din;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/wfc_back.sv =====
// wfc_back: table search, count update, append, and the result register.
// Depends on wfc_pkg.
module wfc_back import wfc_pkg::*; #(
    parameter int MAX_WORDS   = DEF_MAX_WORDS,
    parameter int MAX_LETTERS = DEF_MAX_LETTERS,
    parameter int LEN_W       = $clog2(MAX_LETTERS + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [MAX_LETTERS*LETTER_W-1:0] q_letters,
    input  logic [LEN_W-1:0]                q_len,
    input  logic                            q_ovf,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [INDEX_W-1:0]              m_entry_index,
    output logic [COUNT_W-1:0]              m_word_count,
    output logic                            m_is_new,
    output logic                            m_table_full_drop,
    output logic                            m_word_truncated,
    output logic [OUT_LEN_W-1:0]            m_word_length
);
    localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int UW    = $clog2(MAX_WORDS + 1);
    localparam int ROW_W = MAX_LETTERS * LETTER_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [ROW_W-1:0]   row_mem [MAX_WORDS];
    logic [LEN_W-1:0]   len_mem [MAX_WORDS];
    logic [COUNT_W-1:0] cnt_mem [MAX_WORDS];
    logic [ROW_W-1:0]   row_q;
    logic [LEN_W-1:0]   len_q;
    logic [COUNT_W-1:0] cnt_q;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [ROW_W-1:0]   tok_reg;
    logic [LEN_W-1:0]   tlen_reg;
    logic               tovf_reg;
    logic [AW-1:0]      raddr;
    logic               hit, more;
    logic [UW-1:0]      slot_inc;
    logic [COUNT_W-1:0] cnt_inc;

    logic               wr_row, wr_cnt;
    logic [AW-1:0]      waddr;
    logic [COUNT_W-1:0] wcnt;

    logic [INDEX_W-1:0] r_idx_reg, r_idx_next;
    logic [COUNT_W-1:0] r_cnt_reg, r_cnt_next;
    res_flags_t         r_flg_reg, r_flg_next;
    logic               mv_reg;

    // masked letter compare of the entry read last cycle
    always_comb begin
        hit = (len_q == tlen_reg);
        for (int i = 0; i < MAX_LETTERS; i++) begin
            if (LEN_W'(i) < tlen_reg &&
                row_q[i*LETTER_W +: LETTER_W] != tok_reg[i*LETTER_W +: LETTER_W]) begin
                hit = 1'b0;
            end
        end
    end

    assign slot_inc = {{(UW-AW){1'b0}}, slot_reg} + 1'b1;
    assign more     = slot_inc < used_reg;
    assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
    assign raddr    = (state_reg == ST_IDLE) ? '0 : slot_inc[AW-1:0];
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        used_next  = used_reg;
        wr_row     = 1'b0;
        wr_cnt     = 1'b0;
        waddr      = slot_reg;
        wcnt       = cnt_inc;
        r_idx_next = r_idx_reg;
        r_cnt_next = r_cnt_reg;
        r_flg_next = r_flg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                slot_next = '0;
                if (!q_empty) begin
                    state_next = (used_reg == '0) ? ST_MISS : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    wr_cnt     = 1'b1;
                    r_idx_next = INDEX_W'({{(32-AW){1'b0}}, slot_reg});
                    r_cnt_next = cnt_inc;
                    r_flg_next = '{is_new: 1'b0, table_full_drop: 1'b0,
                                   word_truncated: tovf_reg};
                    state_next = ST_OUT;
                end else if (more) begin
                    slot_next = slot_reg + 1'b1;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                if (used_reg < UW'(MAX_WORDS)) begin
                    wr_row     = 1'b1;
                    wr_cnt     = 1'b1;
                    waddr      = used_reg[AW-1:0];
                    wcnt       = COUNT_W'(1);
                    used_next  = used_reg + 1'b1;
                    r_idx_next = INDEX_W'({{(32-UW){1'b0}}, used_reg});
                    r_cnt_next = COUNT_W'(1);
                    r_flg_next = '{is_new: 1'b1, table_full_drop: 1'b0,
                                   word_truncated: tovf_reg};
                end else begin
                    r_idx_next = '0;
                    r_cnt_next = '0;
                    r_flg_next = '{is_new: 1'b0, table_full_drop: 1'b1,
                                   word_truncated: tovf_reg};
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // table memories: one read port (registered), one write port
    always_ff @(posedge aclk) begin
        row_q <= row_mem[raddr];
        len_q <= len_mem[raddr];
        cnt_q <= cnt_mem[raddr];
        if (wr_row) begin
            row_mem[waddr] <= tok_reg;
            len_mem[waddr] <= tlen_reg;
        end
        if (wr_cnt) begin
            cnt_mem[waddr] <= wcnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tok_reg  <= q_letters;
            tlen_reg <= q_len;
            tovf_reg <= q_ovf;
        end
        r_idx_reg <= r_idx_next;
        r_cnt_reg <= r_cnt_next;
        r_flg_reg <= r_flg_next;
        if (state_reg == ST_OUT && (!mv_reg || m_ready)) begin
            m_entry_index     <= r_idx_reg;
            m_word_count      <= r_cnt_reg;
            m_is_new          <= r_flg_reg.is_new;
            m_table_full_drop <= r_flg_reg.table_full_drop;
            m_word_truncated  <= r_flg_reg.word_truncated;
            m_word_length     <= OUT_LEN_W'({{(32-LEN_W){1'b0}}, tlen_reg});
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            used_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            used_reg  <= used_next;
            if (state_reg == ST_OUT && (!mv_reg || m_ready)) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign m_valid = mv_reg;

endmodule

// ===== src/word_frequency_counter_core.sv =====
// word_frequency_counter_core: top level of the word frequency counter.
// Depends on wfc_pkg, wfc_front, wfc_fifo, wfc_back.
//
//  channel | ports                                  | moves
//  --------+----------------------------------------+-------------------------------
//  s_      | s_valid s_ready s_text_byte s_end_of_text | one text byte per transfer
//  m_      | m_valid m_ready m_entry_index ...      | one result per finished token
//
// Cycles: bytes are taken one per cycle while the token queue has room.
// A finished token is looked up in the back end by scanning the table
// one entry per cycle through one registered read port.
// Reset: aresetn synchronous, active low; table contents need no clearing,
// only the fill count resets. Stalls: the two-entry token queue lets the
// front keep taking bytes while the back scans or waits on m_ready.
module word_frequency_counter_core import wfc_pkg::*; #(
    parameter int MAX_WORDS   = DEF_MAX_WORDS,
    parameter int MAX_LETTERS = DEF_MAX_LETTERS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_end_of_text,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [INDEX_W-1:0]   m_entry_index,
    output logic [COUNT_W-1:0]   m_word_count,
    output logic                 m_is_new,
    output logic                 m_table_full_drop,
    output logic                 m_word_truncated,
    output logic [OUT_LEN_W-1:0] m_word_length
);
    localparam int LEN_W = $clog2(MAX_LETTERS + 1);
    localparam int ROW_W = MAX_LETTERS * LETTER_W;
    localparam int QW    = ROW_W + LEN_W + 1;

    logic             q_full, q_empty, q_push, q_pop;
    logic [ROW_W-1:0] f_letters, b_letters;
    logic [LEN_W-1:0] f_len, b_len;
    logic             f_ovf, b_ovf;
    logic [QW-1:0]    q_out;

    // front: token assembly
    wfc_front #(.MAX_LETTERS(MAX_LETTERS), .LEN_W(LEN_W)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_text_byte, .s_end_of_text,
        .q_full, .q_push, .q_letters(f_letters), .q_len(f_len), .q_ovf(f_ovf)
    );

    // finished-token queue
    wfc_fifo #(.W(QW)) u_fifo (
        .aclk, .aresetn, .push(q_push), .din({f_letters, f_len, f_ovf}),
        .pop(q_pop), .dout(q_out), .full(q_full), .empty(q_empty)
    );

    assign {b_letters, b_len, b_ovf} = q_out;

    // back: table lookup and update
    wfc_back #(.MAX_WORDS(MAX_WORDS), .MAX_LETTERS(MAX_LETTERS), .LEN_W(LEN_W)) u_back (
        .aclk, .aresetn, .q_empty, .q_pop,
        .q_letters(b_letters), .q_len(b_len), .q_ovf(b_ovf),
        .m_valid, .m_ready, .m_entry_index, .m_word_count, .m_is_new,
        .m_table_full_drop, .m_word_truncated, .m_word_length
    );

    // a dropped word carries no count and no new flag
    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full_drop |-> m_word_count == '0 && !m_is_new)
        else $error("dropped word carries count or new flag");

    // a fresh entry always starts at one
    a_new_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_new |-> m_word_count == COUNT_W'(1))
        else $error("new entry count not one");

    // a counted word never shows zero
    a_count_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_table_full_drop |-> m_word_count != '0)
        else $error("counted word has zero count");

endmodule

// ===== tb/sv/tb_word_frequency_counter_core.sv =====
// tb_word_frequency_counter_core: self-checking bench for the word frequency counter.
// Depends on wfc_pkg and word_frequency_counter_core; a local table model predicts
// every result. Text is streamed byte by byte and results are checked in order.
module tb_word_frequency_counter_core;
    import wfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_SLOTS     = DEF_MAX_WORDS;
    localparam int  N_LETTERS   = DEF_MAX_LETTERS;
    localparam int  CYCLE_LIMIT = 1_500_000;

    typedef struct {
        logic [INDEX_W-1:0]   index;
        logic [COUNT_W-1:0]   count;
        logic                 fresh;
        logic                 dropped;
        logic                 truncated;
        logic [OUT_LEN_W-1:0] length;
    } word_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_text_byte;
    logic                 s_end_of_text;
    logic                 m_valid;
    logic                 m_ready;
    logic [INDEX_W-1:0]   m_entry_index;
    logic [COUNT_W-1:0]   m_word_count;
    logic                 m_is_new;
    logic                 m_table_full_drop;
    logic                 m_word_truncated;
    logic [OUT_LEN_W-1:0] m_word_length;

    word_frequency_counter_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .s_end_of_text     (s_end_of_text),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_entry_index     (m_entry_index),
        .m_word_count      (m_word_count),
        .m_is_new          (m_is_new),
        .m_table_full_drop (m_table_full_drop),
        .m_word_truncated  (m_word_truncated),
        .m_word_length     (m_word_length)
    );

    // shadow word table and open-token state
    logic [LETTER_W-1:0]  dict_letters [N_SLOTS][N_LETTERS];
    int                   dict_len     [N_SLOTS];
    logic [COUNT_W-1:0]   dict_count   [N_SLOTS];
    int                   dict_used;
    logic [LETTER_W-1:0]  tok_letters  [N_LETTERS];
    int                   tok_len;
    bit                   tok_open;
    bit                   tok_cut;

    word_result_t pending_results[$];
    int           fail_count;
    int           cycle_count;
    bit           calm;        // no idling on either side
    int           rx_hold;     // long receiver hold-off, in cycles
    int           rx_gap;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report(input string what);
        fail_count++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // predictor: a token closes on whitespace or on end of text
    // ---------------------------------------------------------------
    function automatic int find_word();
        for (int s = 0; s < dict_used; s++) begin
            bit same;
            same = (dict_len[s] == tok_len);
            for (int i = 0; same && i < tok_len; i++)
                if (dict_letters[s][i] != tok_letters[i]) same = 0;
            if (same) return s;
        end
        return -1;
    endfunction

    task automatic close_word();
        word_result_t r;
        int slot;
        slot = find_word();
        r.fresh = 0;
        r.dropped = 0;
        r.index = '0;
        r.count = '0;
        if (slot >= 0) begin
            if (dict_count[slot] != COUNT_MAX) dict_count[slot]++;
            r.index = slot[INDEX_W-1:0];
            r.count = dict_count[slot];
        end else if (dict_used < N_SLOTS) begin
            for (int i = 0; i < N_LETTERS; i++) dict_letters[dict_used][i] = tok_letters[i];
            dict_len[dict_used] = tok_len;
            dict_count[dict_used] = COUNT_W'(1);
            r.index = dict_used[INDEX_W-1:0];
            r.count = COUNT_W'(1);
            r.fresh = 1;
            dict_used++;
        end else begin
            // table full: word is lost, table untouched
            r.dropped = 1;
        end
        r.truncated = tok_cut;
        r.length = tok_len[OUT_LEN_W-1:0];
        pending_results.push_back(r);
        tok_len = 0;
        tok_open = 0;
        tok_cut = 0;
    endtask

    task automatic tally_byte(input logic [7:0] b, input logic eot);
        logic [7:0] c;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
            if (tok_open) close_word();
            return;
        end
        tok_open = 1;
        c = b;
        if (c >= CH_LA && c <= CH_LZ) c = c - 8'd32;
        if (c >= CH_UA && c <= CH_UZ) begin
            if (tok_len < N_LETTERS) begin
                tok_letters[tok_len] = LETTER_W'(c - CH_UA);
                tok_len++;
            end else begin
                tok_cut = 1;
            end
        end
        if (eot) close_word();
    endtask

    // ---------------------------------------------------------------
    // result checker: handshake sampled at the edge, before updates land
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("result with nothing expected");
            end else begin
                word_result_t e;
                e = pending_results.pop_front();
                if (m_entry_index !== e.index)
                    report($sformatf("entry_index %0d, want %0d", m_entry_index, e.index));
                if (m_word_count !== e.count)
                    report($sformatf("word_count %0d, want %0d", m_word_count, e.count));
                if (m_is_new !== e.fresh)
                    report($sformatf("is_new %0b, want %0b", m_is_new, e.fresh));
                if (m_table_full_drop !== e.dropped)
                    report($sformatf("table_full_drop %0b, want %0b",
                                     m_table_full_drop, e.dropped));
                if (m_word_truncated !== e.truncated)
                    report($sformatf("word_truncated %0b, want %0b",
                                     m_word_truncated, e.truncated));
                if (m_word_length !== e.length)
                    report($sformatf("word_length %0d, want %0d", m_word_length, e.length));
            end
        end
    end

    // receiver: random stall bursts, or a long counted hold-off
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!(s_valid && s_ready));
        tally_byte(b, eot);
    endtask

    task automatic send_text(input string txt, input bit eot_last);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], eot_last && i == txt.len() - 1);
    endtask

    // sender stops until every word result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 6);
        return (k == 6) ? CH_SPACE : 8'(CH_TAB + k[7:0] % 5);
    endfunction

    function automatic logic [7:0] pick_letter(input int span);
        logic [7:0] base;
        base = $urandom_range(0, 1) ? CH_LA : CH_UA;
        return base + 8'($urandom_range(0, span - 1));
    endfunction

    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
        return b;
    endfunction

    // one random token followed by separators
    task automatic send_random_word(input int span);
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            logic last;
            last = (i == n - 1) && ($urandom_range(0, 15) == 0);
            if ($urandom_range(0, 9) == 0) send_byte(pick_noise(), last);
            else send_byte(pick_letter(span), last);
        end
        repeat ($urandom_range(1, 2)) send_byte(pick_blank(), $urandom_range(0, 20) == 0);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        send_byte(CH_SPACE, 1'b0);              // blanks outside a token: no result
        send_byte(CH_TAB, 1'b1);                // end of text on idle blank
        send_text("Az ", 0);                    // new word
        send_text("aZ@", 1);                    // same word, end on a non-letter
        send_text("[`{", 0);                    // boundary non-letters: empty word
        send_byte(CH_CR, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd128, 1'b0);
        send_byte(8'd11, 1'b1);                 // empty word again, eot on a blank
        send_text("zA", 0);
        send_byte(8'd10, 1'b0);
        send_text("Zz", 1);                     // end of text on a letter
        drain();
    endtask

    task automatic test_long_tokens();
        for (int i = 0; i < N_LETTERS; i++) send_byte(pick_letter(26), 1'b0);
        send_byte(CH_SPACE, 1'b0);              // exactly at the letter limit
        for (int i = 0; i < N_LETTERS + 8; i++) send_byte(pick_letter(2), 1'b0);
        send_byte(CH_SPACE, 1'b0);              // cut off, flagged
    endtask

    task automatic test_random(input int n_words);
        for (int w = 0; w < n_words; w++) send_random_word($urandom_range(2, 5));
    endtask

    // receiver holds off while text keeps coming, so the token queue fills
    task automatic test_backpressure();
        drain();
        rx_hold = 600;
        for (int w = 0; w < 20; w++) send_random_word(3);
        drain();
    endtask

    // fill the table with two-letter words from F..Z, then overflow it
    task automatic test_table_full();
        int i;
        int extra;
        i = 0;
        extra = 0;
        while (extra < 6) begin
            if (dict_used >= N_SLOTS) extra++;
            send_byte(CH_UA + 8'd5 + 8'(i / 21), 1'b0);
            send_byte(CH_UA + 8'd5 + 8'(i % 21), 1'b0);
            send_byte(CH_SPACE, 1'b0);
            i++;
        end
        test_random(10);                        // lookups against a full table
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_text_byte = '0;
        s_end_of_text = 1'b0;
        m_ready = 1'b0;
        calm = 0;
        rx_hold = 0;
        rx_gap = 0;
        fail_count = 0;
        dict_used = 0;
        tok_len = 0;
        tok_open = 0;
        tok_cut = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_long_tokens();
        test_random(20);
        test_backpressure();
        test_random(15);
        test_table_full();
        calm = 1;                               // last stretch at full rate
        test_random(20);
        drain();
        repeat (N_SLOTS + 50) @(posedge aclk);

        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
